FILE: src/ksfl_pkg.sv
package ksfl_pkg;

	// Transaction field widths
	localparam int CMD_W  = 1;
	localparam int SN_W   = 3;
	localparam int ST_W   = 2;
	localparam int CFG_W  = 4;

	// Register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [0:0] REG_STACKS_IN_USE = 1'b0;
	localparam logic [CFG_W-1:0] STACKS_RESET = 4'd8;

	// Commands
	localparam logic [CMD_W-1:0] CMD_PUSH = 1'b0;
	localparam logic [CMD_W-1:0] CMD_POP  = 1'b1;

	// Result status codes
	localparam logic [ST_W-1:0] ST_OK        = 2'd0;
	localparam logic [ST_W-1:0] ST_INVALID   = 2'd1;
	localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [ST_W-1:0] ST_UNDERFLOW = 2'd3;

	// Controller commands to the datapath
	typedef struct packed {
		logic load_req;
		logic do_read;
		logic do_update;
	} ctrl_t;

endpackage

FILE: src/ksfl_ctrl.sv
module ksfl_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            out_stall,
	output logic            in_stall,
	output logic            out_valid,
	output ksfl_pkg::ctrl_t ctrl
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   can_load;
	logic   accept;

	// Output register is free when empty or being taken this cycle
	assign can_load = !out_valid_q || !out_stall;
	assign in_stall = !((state_q == S_IDLE) || ((state_q == S_UPDATE) && can_load));
	assign accept   = in_valid && !in_stall;

	assign ctrl.load_req  = accept;
	assign ctrl.do_read   = (state_q == S_READ);
	assign ctrl.do_update = (state_q == S_UPDATE) && can_load;
	assign out_valid      = out_valid_q;

	// Sequence each transaction through read and update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (can_load) begin
						state_q <= accept ? S_READ : S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if ((state_q == S_UPDATE) && can_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

FILE: src/ksfl_datapath.sv
module ksfl_datapath #(
	parameter int CAPACITY   = 64,
	parameter int NUM_STACKS = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  ksfl_pkg::ctrl_t             ctrl,
	input  logic [ksfl_pkg::CFG_W-1:0]  stacks_in_use,
	input  logic [ksfl_pkg::CMD_W-1:0]  command,
	input  logic [ksfl_pkg::SN_W-1:0]   stack_number,
	input  logic [DATA_WIDTH-1:0]       push_value,
	output logic [DATA_WIDTH-1:0]       pop_value,
	output logic [ksfl_pkg::ST_W-1:0]   status,
	output logic                        store_full,
	output logic                        stack_empty
);

	localparam int AW = $clog2(CAPACITY);
	localparam int PW = $clog2(CAPACITY + 1);
	localparam int SW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam logic [PW-1:0] PTR_NONE = PW'(CAPACITY);

	// Request registers
	logic [ksfl_pkg::CMD_W-1:0] cmd_q;
	logic [ksfl_pkg::SN_W-1:0]  sn_q;
	logic [DATA_WIDTH-1:0]      value_q;

	// Stack state
	logic [PW-1:0] free_head_q;
	logic [PW-1:0] fill_q;
	logic [PW-1:0] tops_q [NUM_STACKS];

	// Shared stores
	logic [PW-1:0]         link_mem_q [CAPACITY];
	logic [DATA_WIDTH-1:0] data_mem_q [CAPACITY];

	// Read stage results
	logic [PW-1:0]          slot_q;
	logic [ksfl_pkg::ST_W-1:0] status_q;
	logic [PW-1:0]          link_rd_q;
	logic [DATA_WIDTH-1:0]  data_rd_q;

	logic [SW-1:0]          sn_idx;
	logic                   sn_bad;
	logic [PW-1:0]          top_cur;
	logic [PW-1:0]          slot_d;
	logic [ksfl_pkg::ST_W-1:0] status_d;
	logic [PW-1:0]          link_eff;
	logic                   push_ok;
	logic                   pop_ok;
	logic [PW-1:0]          free_next;
	logic [PW-1:0]          top_next;

	// Decode the addressed stack and pick the slot
	always_comb begin
		sn_idx  = SW'(sn_q);
		sn_bad  = ({1'b0, sn_q} >= stacks_in_use) || (32'(sn_q) >= NUM_STACKS);
		top_cur = sn_bad ? PTR_NONE : tops_q[sn_idx];
		slot_d  = (cmd_q == ksfl_pkg::CMD_PUSH) ? free_head_q : top_cur;
		if (sn_bad) begin
			status_d = ksfl_pkg::ST_INVALID;
		end else if ((cmd_q == ksfl_pkg::CMD_PUSH) && !(free_head_q < PTR_NONE)) begin
			status_d = ksfl_pkg::ST_OVERFLOW;
		end else if ((cmd_q == ksfl_pkg::CMD_POP) && !(top_cur < PTR_NONE)) begin
			status_d = ksfl_pkg::ST_UNDERFLOW;
		end else begin
			status_d = ksfl_pkg::ST_OK;
		end
	end

	// Work out the new pointers; entries at or above the fill count still link to the next one
	always_comb begin
		link_eff  = (slot_q < fill_q) ? link_rd_q : slot_q + PW'(1);
		push_ok   = (status_q == ksfl_pkg::ST_OK) && (cmd_q == ksfl_pkg::CMD_PUSH);
		pop_ok    = (status_q == ksfl_pkg::ST_OK) && (cmd_q == ksfl_pkg::CMD_POP);
		free_next = free_head_q;
		top_next  = top_cur;
		if (push_ok) begin
			free_next = link_eff;
			top_next  = slot_q;
		end else if (pop_ok) begin
			free_next = slot_q;
			top_next  = link_eff;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (ctrl.load_req) begin
			cmd_q   <= command;
			sn_q    <= stack_number;
			value_q <= push_value;
		end
	end

	// Read stage: slot, status and registered store reads
	always_ff @(posedge clk) begin
		if (ctrl.do_read) begin
			slot_q   <= slot_d;
			status_q <= status_d;
			if (slot_d < PTR_NONE) begin
				link_rd_q <= link_mem_q[slot_d[AW-1:0]];
				data_rd_q <= data_mem_q[slot_d[AW-1:0]];
			end
		end
	end

	// Update stage: store writes
	always_ff @(posedge clk) begin
		if (ctrl.do_update) begin
			if (push_ok) begin
				link_mem_q[slot_q[AW-1:0]] <= top_cur;
				data_mem_q[slot_q[AW-1:0]] <= value_q;
			end else if (pop_ok) begin
				link_mem_q[slot_q[AW-1:0]] <= free_head_q;
			end
		end
	end

	// Update stage: pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			fill_q      <= '0;
			for (int i = 0; i < NUM_STACKS; i++) begin
				tops_q[i] <= PTR_NONE;
			end
		end else if (ctrl.do_update) begin
			free_head_q <= free_next;
			if (push_ok || pop_ok) begin
				tops_q[sn_idx] <= top_next;
			end
			if (push_ok && (slot_q == fill_q)) begin
				fill_q <= fill_q + PW'(1);
			end
		end
	end

	// Load the result register
	always_ff @(posedge clk) begin
		if (ctrl.do_update) begin
			pop_value   <= pop_ok ? data_rd_q : '0;
			status      <= status_q;
			store_full  <= !(free_next < PTR_NONE);
			stack_empty <= !(top_next < PTR_NONE);
		end
	end

endmodule

FILE: src/k_stacks_shared_free_list_unit.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+------------------------------------------------
// input    | in_valid / in_stall  | command, stack_number, push_value
// output   | out_valid / out_stall| pop_value, status, store_full, stack_empty
// register | APB psel/penable     | stacks_in_use at byte address 0
//
// No new transaction is taken before the last reaches its update: the top pointer or free
// head selects a slot, then the link and data stores are read through their registered
// ports before the update. Each goes through the request, read and result registers.
// After reset the unit is ready at once: a fill count stands in for the initial link chain.
// A stalled result holds the update stage, and with it new transactions.
module k_stacks_shared_free_list_unit #(
	parameter int CAPACITY   = 64,
	parameter int NUM_STACKS = 8,
	parameter int DATA_WIDTH = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [ksfl_pkg::CMD_W-1:0]    command,
	input  logic [ksfl_pkg::SN_W-1:0]     stack_number,
	input  logic [DATA_WIDTH-1:0]         push_value,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [DATA_WIDTH-1:0]         pop_value,
	output logic [ksfl_pkg::ST_W-1:0]     status,
	output logic                          store_full,
	output logic                          stack_empty,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ksfl_pkg::PADDR_W-1:0]  paddr,
	input  logic [ksfl_pkg::PDATA_W-1:0]  pwdata,
	output logic [ksfl_pkg::PDATA_W-1:0]  prdata,
	output logic                          pready
);

	ksfl_pkg::ctrl_t            ctrl;
	logic [ksfl_pkg::CFG_W-1:0] stacks_in_use_q;
	logic                       reg_sel;

	// Register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[2] == ksfl_pkg::REG_STACKS_IN_USE);
	assign prdata  = reg_sel ? ksfl_pkg::PDATA_W'(stacks_in_use_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stacks_in_use_q <= ksfl_pkg::STACKS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			stacks_in_use_q <= pwdata[ksfl_pkg::CFG_W-1:0];
		end
	end

	ksfl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_stall (out_stall),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.ctrl      (ctrl)
	);

	ksfl_datapath #(
		.CAPACITY   (CAPACITY),
		.NUM_STACKS (NUM_STACKS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctrl          (ctrl),
		.stacks_in_use (stacks_in_use_q),
		.command       (command),
		.stack_number  (stack_number),
		.push_value    (push_value),
		.pop_value     (pop_value),
		.status        (status),
		.store_full    (store_full),
		.stack_empty   (stack_empty)
	);

	// A transaction is followed by a read cycle with input stalled
	a_read_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken during read cycle");

	// Every accepted transaction has a result pending after its read and update states
	a_result_due: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> ##3 out_valid)
		else $error("result missing after transaction");

	// Overflow only when the free list is exhausted
	a_overflow_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (status == ksfl_pkg::ST_OVERFLOW)) |-> store_full)
		else $error("overflow reported with free entries");

	// Rejected or underflowing stacks report empty
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && ((status == ksfl_pkg::ST_INVALID) ||
		(status == ksfl_pkg::ST_UNDERFLOW))) |-> stack_empty)
		else $error("empty flag clear on failed transaction");

endmodule

FILE: tb/tb_k_stacks_shared_free_list_unit.sv
module tb_k_stacks_shared_free_list_unit;
	import ksfl_pkg::*;

	localparam int DEPTH       = 64;
	localparam int NSTK        = 8;
	localparam int DW          = 32;
	localparam logic [6:0] NIL = 7'd64;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_MAX  = 10;
	localparam int SCRIPT_LEN  = 26;

	typedef struct packed {
		logic [DW-1:0]   pop_value;
		logic [ST_W-1:0] status;
		logic            store_full;
		logic            stack_empty;
	} stack_result_t;

	typedef enum logic {ROW_OP, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CMD_W-1:0] cmd;
		logic [SN_W-1:0]  sn;
		logic [DW-1:0]    val;
		logic             typed;
		stack_result_t    want;
	} script_row_t;

	// Opening sequence: extremes, both commands, ok, underflow and invalid status, register edge values
	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_OP,  CMD_POP,  3'd0, 32'h0,        1'b1, '{32'h0, ST_UNDERFLOW, 1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd7, 32'hFFFFFFFF, 1'b1, '{32'h0, ST_UNDERFLOW, 1'b0, 1'b1}},
		'{ROW_OP,  CMD_PUSH, 3'd0, 32'h0,        1'b1, '{32'h0, ST_OK,        1'b0, 1'b0}},
		'{ROW_OP,  CMD_PUSH, 3'd0, 32'hFFFFFFFF, 1'b1, '{32'h0, ST_OK,        1'b0, 1'b0}},
		'{ROW_OP,  CMD_PUSH, 3'd7, 32'hA5A5A5A5, 1'b1, '{32'h0, ST_OK,        1'b0, 1'b0}},
		'{ROW_OP,  CMD_POP,  3'd0, 32'h0,        1'b1, '{32'hFFFFFFFF, ST_OK, 1'b0, 1'b0}},
		'{ROW_OP,  CMD_POP,  3'd0, 32'h0,        1'b1, '{32'h0, ST_OK,        1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd0, 32'h0,        1'b1, '{32'h0, ST_UNDERFLOW, 1'b0, 1'b1}},
		'{ROW_OP,  CMD_PUSH, 3'd3, 32'h80000001, 1'b1, '{32'h0, ST_OK,        1'b0, 1'b0}},
		'{ROW_OP,  CMD_POP,  3'd7, 32'h0,        1'b1, '{32'hA5A5A5A5, ST_OK, 1'b0, 1'b1}},
		'{ROW_OP,  CMD_PUSH, 3'd5, 32'h5A5A5A5A, 1'b0, '0},
		'{ROW_OP,  CMD_PUSH, 3'd5, 32'h12345678, 1'b0, '0},
		'{ROW_OP,  CMD_POP,  3'd3, 32'h0,        1'b1, '{32'h80000001, ST_OK, 1'b0, 1'b1}},
		'{ROW_CFG, CMD_PUSH, 3'd0, 32'd4,        1'b0, '0},
		'{ROW_OP,  CMD_PUSH, 3'd4, 32'h0000FFFF, 1'b1, '{32'h0, ST_INVALID,   1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd7, 32'h0,        1'b1, '{32'h0, ST_INVALID,   1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd5, 32'h0,        1'b1, '{32'h0, ST_INVALID,   1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd3, 32'h0,        1'b1, '{32'h0, ST_UNDERFLOW, 1'b0, 1'b1}},
		'{ROW_CFG, CMD_PUSH, 3'd0, 32'd0,        1'b0, '0},
		'{ROW_OP,  CMD_PUSH, 3'd0, 32'hFFFF0000, 1'b1, '{32'h0, ST_INVALID,   1'b0, 1'b1}},
		'{ROW_OP,  CMD_POP,  3'd0, 32'h0,        1'b1, '{32'h0, ST_INVALID,   1'b0, 1'b1}},
		'{ROW_CFG, CMD_PUSH, 3'd0, 32'd15,       1'b0, '0},
		'{ROW_OP,  CMD_POP,  3'd5, 32'h0,        1'b0, '0},
		'{ROW_OP,  CMD_POP,  3'd5, 32'h0,        1'b0, '0},
		'{ROW_OP,  CMD_PUSH, 3'd7, 32'h00000001, 1'b0, '0},
		'{ROW_OP,  CMD_POP,  3'd7, 32'h0,        1'b0, '0}
	};

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_stall;
	logic [CMD_W-1:0]    command;
	logic [SN_W-1:0]     stack_number;
	logic [DW-1:0]       push_value;
	logic                out_valid;
	logic                out_stall;
	logic [DW-1:0]       pop_value;
	logic [ST_W-1:0]     status;
	logic                store_full;
	logic                stack_empty;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	// Shadow of the stack store
	logic [DW-1:0] shadow_data [DEPTH];
	logic [6:0]    shadow_link [DEPTH];
	logic [6:0]    shadow_top  [NSTK];
	logic [6:0]    shadow_free;
	logic [CFG_W-1:0] shadow_count;

	stack_result_t pending_results [$];
	stack_result_t row_want;
	bit            row_typed;
	bit            calm;
	int            stall_left;
	int            cycle_count;
	int            mismatch_count;
	int            status_tally [4];
	int            settings_used;

	k_stacks_shared_free_list_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.stack_number (stack_number),
		.push_value   (push_value),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.pop_value    (pop_value),
		.status       (status),
		.store_full   (store_full),
		.stack_empty  (stack_empty),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// Apply one push or pop to the shadow store and return what the unit should report
	function automatic stack_result_t apply_stack_op(input logic [CMD_W-1:0] cmd,
			input logic [SN_W-1:0] sn, input logic [DW-1:0] word);
		stack_result_t r;
		logic [6:0] slot;
		r = '0;
		r.status = ST_OK;
		r.stack_empty = 1'b1;
		if (int'(sn) >= int'(shadow_count) || int'(sn) >= NSTK) begin
			r.status = ST_INVALID;
		end else if (cmd == CMD_PUSH) begin
			if (shadow_free >= NIL) begin
				r.status = ST_OVERFLOW;
			end else begin
				slot = shadow_free;
				shadow_free = shadow_link[slot];
				shadow_link[slot] = shadow_top[sn];
				shadow_top[sn] = slot;
				shadow_data[slot] = word;
			end
			r.stack_empty = shadow_top[sn] >= NIL;
		end else begin
			if (shadow_top[sn] >= NIL) begin
				r.status = ST_UNDERFLOW;
			end else begin
				slot = shadow_top[sn];
				shadow_top[sn] = shadow_link[slot];
				shadow_link[slot] = shadow_free;
				shadow_free = slot;
				r.pop_value = shadow_data[slot];
			end
			r.stack_empty = shadow_top[sn] >= NIL;
		end
		r.store_full = shadow_free >= NIL;
		return r;
	endfunction

	// Gap length: none while calm, else mostly none or short, now and then long
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (calm) return 0;
		if (r < 60) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	task automatic note_mismatch(input string what, input stack_result_t want,
			input stack_result_t got);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX) begin
			$display("MISMATCH %s at cycle %0d: want pop=%h st=%0d full=%0b empty=%0b,",
				what, cycle_count, want.pop_value, want.status, want.store_full,
				want.stack_empty);
			$display("    got pop=%h st=%0d full=%0b empty=%0b",
				got.pop_value, got.status, got.store_full, got.stack_empty);
		end
	endtask

	// Check each result transaction and predict each accepted one
	always @(posedge clk) begin
		stack_result_t got;
		stack_result_t want;
		stack_result_t pred;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = '{pop_value, status, store_full, stack_empty};
				if (pending_results.size() == 0) begin
					note_mismatch("unexpected result", '0, got);
				end else begin
					want = pending_results.pop_front();
					if (got.pop_value !== want.pop_value || got.status !== want.status ||
							got.store_full !== want.store_full ||
							got.stack_empty !== want.stack_empty) begin
						note_mismatch("result", want, got);
					end
				end
			end
			if (in_valid && !in_stall) begin
				pred = apply_stack_op(command, stack_number, push_value);
				status_tally[pred.status]++;
				pending_results.push_back(row_typed ? row_want : pred);
			end
		end
	end

	// Stall the result side in random bursts
	always @(negedge clk) begin
		int n;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			n = pick_gap();
			out_stall <= n > 0;
			stall_left = n > 0 ? n - 1 : 0;
		end
	end

	// Offer one transaction after a random gap and hold it until accepted
	task automatic send_op(input logic [CMD_W-1:0] cmd, input logic [SN_W-1:0] sn,
			input logic [DW-1:0] word, input bit typed, input stack_result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		row_typed = typed;
		row_want = want;
		in_valid <= 1'b1;
		command <= cmd;
		stack_number <= sn;
		push_value <= word;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write the stack count, then read it back
	task automatic write_stack_count(input logic [CFG_W-1:0] value);
		logic [PDATA_W-1:0] word;
		word = $urandom();
		word[CFG_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {REG_STACKS_IN_USE, 2'b00};
		pwdata <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[CFG_W-1:0] !== value) begin
			mismatch_count++;
			if (mismatch_count <= REPORT_MAX)
				$display("MISMATCH register readback: want %0d, got %0d", value,
					prdata[CFG_W-1:0]);
		end
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		shadow_count = value;
		settings_used++;
	endtask

	// Random mix of pushes and pops, mostly on stacks that are in use
	task automatic run_mix(input int count, input int push_pct);
		logic [CMD_W-1:0] cmd;
		logic [SN_W-1:0] sn;
		int lim;
		for (int i = 0; i < count; i++) begin
			cmd = ($urandom_range(0, 99) < push_pct) ? CMD_PUSH : CMD_POP;
			lim = (shadow_count > NSTK) ? NSTK : int'(shadow_count);
			if (lim > 0 && $urandom_range(0, 99) < 85)
				sn = SN_W'($urandom_range(0, lim - 1));
			else
				sn = SN_W'($urandom_range(0, NSTK - 1));
			send_op(cmd, sn, $urandom(), 1'b0, '0);
		end
	endtask

	initial begin
		int plan_count [7];
		int plan_push [7];
		logic [SN_W-1:0] sn;

		plan_count = '{8, 1, 3, 15, 0, 6, 8};
		plan_push = '{70, 60, 50, 65, 50, 30, 40};
		arst_n = 1'b0;
		in_valid = 1'b0;
		command = CMD_PUSH;
		stack_number = '0;
		push_value = '0;
		out_stall = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		row_typed = 1'b0;
		row_want = '0;
		calm = 1'b0;
		stall_left = 0;
		mismatch_count = 0;
		settings_used = 0;
		status_tally = '{0, 0, 0, 0};

		// Reset state of the shadow store
		for (int i = 0; i < DEPTH; i++) begin
			shadow_data[i] = '0;
			shadow_link[i] = 7'(i + 1);
		end
		for (int i = 0; i < NSTK; i++) shadow_top[i] = NIL;
		shadow_free = '0;
		shadow_count = STACKS_RESET;

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed opening
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_CFG) begin
				settle();
				write_stack_count(SCRIPT[i].val[CFG_W-1:0]);
			end else begin
				send_op(SCRIPT[i].cmd, SCRIPT[i].sn, SCRIPT[i].val, SCRIPT[i].typed,
					SCRIPT[i].want);
			end
		end

		// Random phases, each under its own stack count
		for (int p = 0; p < 8; p++) begin
			settle();
			calm = (p % 3 == 2);
			if (p < 7) begin
				write_stack_count(CFG_W'(plan_count[p]));
				run_mix(plan_count[p] == 0 ? 20 : 60, plan_push[p]);
			end else begin
				write_stack_count(CFG_W'($urandom_range(0, 15)));
				run_mix(40, 55);
			end
		end

		// Fill the store to overflow, then empty every stack past underflow
		settle();
		calm = 1'b0;
		write_stack_count(CFG_W'(8));
		while (shadow_free < NIL) send_op(CMD_PUSH, SN_W'($urandom_range(0, NSTK - 1)),
			$urandom(), 1'b0, '0);
		repeat (3) send_op(CMD_PUSH, SN_W'($urandom_range(0, NSTK - 1)), $urandom(),
			1'b0, '0);
		for (int s = 0; s < NSTK; s++) begin
			sn = SN_W'(s);
			while (shadow_top[s] < NIL) send_op(CMD_POP, sn, $urandom(), 1'b0, '0);
			send_op(CMD_POP, sn, $urandom(), 1'b0, '0);
		end

		settle();
		repeat (10) @(negedge clk);
		$display("Covered %0d ok, %0d invalid-stack, %0d overflow and %0d underflow",
			status_tally[ST_OK], status_tally[ST_INVALID], status_tally[ST_OVERFLOW],
			status_tally[ST_UNDERFLOW]);
		$display("transactions over %0d stack-count settings, %0d mismatches",
			settings_used, mismatch_count);
		if (mismatch_count == 0 && pending_results.size() == 0) begin
			$display("k_stacks_shared_free_list_unit verification clean");
		end else begin
			$display("k_stacks_shared_free_list_unit verification failed");
		end
		$finish;
	end

	// Abandon a run that hangs
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("Timed out after %0d cycles with %0d results outstanding", cycle_count,
			pending_results.size());
		$display("k_stacks_shared_free_list_unit verification failed");
		$finish;
	end

endmodule

FILE: k_stacks_shared_free_list_unit.f
src/ksfl_pkg.sv
src/ksfl_ctrl.sv
src/ksfl_datapath.sv
src/k_stacks_shared_free_list_unit.sv
tb/tb_k_stacks_shared_free_list_unit.sv
